/* rtl/core/mbps_pkg.sv */
package mbps_pkg;

  localparam int unsigned DataW      = 8;
  localparam int unsigned AddrW      = 64;
  localparam int unsigned CfgDataW   = 64;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned PatLenW    = 6;
  localparam int unsigned CareW      = 32;
  localparam int unsigned PatBytes   = 32;
  localparam int unsigned PatW       = PatBytes * DataW;
  // wide enough for any length arithmetic up to a 64-byte window
  localparam int unsigned IdxW       = 7;
  localparam int unsigned MaxPatternLenDef = 32;

  // register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_REGION_BASE   = 3'd0,
    REG_PATTERN_LEN   = 3'd1,
    REG_CARE_MASK     = 3'd2,
    REG_PATTERN_WORD0 = 3'd3,
    REG_PATTERN_WORD1 = 3'd4,
    REG_PATTERN_WORD2 = 3'd5,
    REG_PATTERN_WORD3 = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [DataW-1:0] data_byte;
    logic             last_byte;
  } in_item_t;

  typedef struct packed {
    logic             found;
    logic [AddrW-1:0] match_address;
  } out_item_t;

  // stage 1 status towards the compare / result stage
  typedef struct packed {
    logic             valid;
    logic             last;
    logic [AddrW-1:0] offset;
  } s1_stat_t;

endpackage

/* rtl/core/mbps_window.sv */
module mbps_window #(
  parameter int unsigned MAX_PATTERN_LEN = mbps_pkg::MaxPatternLenDef,
  parameter int unsigned LenW            = $clog2(MAX_PATTERN_LEN + 1)
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  mbps_pkg::in_item_t               in_data,
  input  logic                             s2_go,
  output mbps_pkg::s1_stat_t               s1_stat,
  output logic [LenW-1:0]                  bytes_seen,
  output logic [MAX_PATTERN_LEN*mbps_pkg::DataW-1:0] window
);

  localparam int unsigned DW = mbps_pkg::DataW;

  logic [DW-1:0]              win_r [MAX_PATTERN_LEN];
  logic                       s1_valid_r;
  logic                       s1_last_r;
  logic [mbps_pkg::AddrW-1:0] offset_r;
  logic [LenW-1:0]            seen_r;
  logic                       start_r;   // next byte opens a new region
  logic                       accept;

  assign in_stall = s1_valid_r && !s2_go;
  assign accept   = in_valid && !in_stall;

  // shift line, newest byte in entry 0; stale entries are masked by seen_r
  always_ff @(posedge clk) begin
    if (accept) begin
      win_r[0] <= in_data.data_byte;
      for (int k = 1; k < MAX_PATTERN_LEN; k++) begin
        win_r[k] <= win_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s1_last_r  <= 1'b0;
      offset_r   <= '0;
      seen_r     <= '0;
      start_r    <= 1'b1;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
      s1_last_r  <= in_data.last_byte;
      start_r    <= in_data.last_byte;
      if (start_r) begin
        offset_r <= mbps_pkg::AddrW'(1);
        seen_r   <= LenW'(1);
      end else begin
        offset_r <= offset_r + mbps_pkg::AddrW'(1);
        if (seen_r != LenW'(MAX_PATTERN_LEN)) begin
          seen_r <= seen_r + LenW'(1);
        end
      end
    end else if (s2_go) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_comb begin
    for (int k = 0; k < MAX_PATTERN_LEN; k++) begin
      window[k*DW +: DW] = win_r[k];
    end
  end

  assign s1_stat.valid  = s1_valid_r;
  assign s1_stat.last   = s1_last_r;
  assign s1_stat.offset = offset_r;
  assign bytes_seen     = seen_r;

endmodule

/* rtl/core/mbps_match.sv */
module mbps_match #(
  parameter int unsigned MAX_PATTERN_LEN = mbps_pkg::MaxPatternLenDef,
  parameter int unsigned LenW            = $clog2(MAX_PATTERN_LEN + 1)
) (
  input  logic [MAX_PATTERN_LEN*mbps_pkg::DataW-1:0] window,
  input  logic [LenW-1:0]                  bytes_seen,
  input  logic [LenW-1:0]                  len,
  input  logic [mbps_pkg::CareW-1:0]       care_mask,
  input  logic [mbps_pkg::PatW-1:0]        pattern,
  output logic                             match
);

  localparam int unsigned DW = mbps_pkg::DataW;
  localparam int unsigned IW = mbps_pkg::IdxW;

  logic [MAX_PATTERN_LEN-1:0] miss;

  // window entry k lines up with pattern byte len-1-k
  for (genvar k = 0; k < MAX_PATTERN_LEN; k++) begin : g_pos
    logic [IW-1:0] j;
    logic          active;
    logic          care;
    logic [DW-1:0] pb;
    always_comb begin
      j      = IW'(len) - IW'(1) - IW'(k);
      active = IW'(k) < IW'(len);
      care   = (j < IW'(mbps_pkg::CareW)) && care_mask[j[4:0]];
      pb     = pattern[j[4:0]*DW +: DW];
      miss[k] = active && care && (window[k*DW +: DW] != pb);
    end
  end

  assign match = (len == '0) || ((bytes_seen >= len) && (miss == '0));

endmodule

/* rtl/core/masked_byte_pattern_scan.sv */
// Masked byte signature scan.
// Input channel (in_valid / in_stall / in_data): one byte of the region per
// transfer, with last_byte set on the region's final byte.
// Result channel (out_valid / out_stall / out_data): at most one transfer per
// region - found with region base plus match offset on the first match, or
// found = 0 and a zero address when the region ends without a match.
// Configuration: cfg_we / cfg_index / cfg_data write one register per clock;
// the user must write only while no byte is in flight, the block itself does
// not enforce it. Throughput: one byte per cycle while no result is held by
// out_stall. A byte passes through the window register, then the parallel
// window compare into the result register, which drives out_data.
// Reset (rst_n low, synchronous): configuration registers to zero, the region
// rearmed, both pipeline stages empty.
// A stalled result holds; in_stall rises only when the window stage is full
// and the result register is held by out_stall, so one more byte is taken
// while a result waits before the input backs up.
module masked_byte_pattern_scan #(
  parameter int unsigned MAX_PATTERN_LEN = mbps_pkg::MaxPatternLenDef
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  mbps_pkg::in_item_t             in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output mbps_pkg::out_item_t            out_data,
  input  logic                           cfg_we,
  input  logic [mbps_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [mbps_pkg::CfgDataW-1:0]  cfg_data
);

  localparam int unsigned LenW = $clog2(MAX_PATTERN_LEN + 1);
  localparam int unsigned IW   = mbps_pkg::IdxW;
  localparam int unsigned AW   = mbps_pkg::AddrW;

  // configuration registers
  logic [AW-1:0]                   base_r;
  logic [mbps_pkg::PatLenW-1:0]    plen_r;
  logic [mbps_pkg::CareW-1:0]      care_r;
  logic [mbps_pkg::PatW-1:0]       pattern_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r    <= '0;
      plen_r    <= '0;
      care_r    <= '0;
      pattern_r <= '0;
    end else if (cfg_we) begin
      unique case (mbps_pkg::cfg_reg_t'(cfg_index))
        mbps_pkg::REG_REGION_BASE:   base_r <= cfg_data;
        mbps_pkg::REG_PATTERN_LEN:   plen_r <= cfg_data[mbps_pkg::PatLenW-1:0];
        mbps_pkg::REG_CARE_MASK:     care_r <= cfg_data[mbps_pkg::CareW-1:0];
        mbps_pkg::REG_PATTERN_WORD0: pattern_r[0*64 +: 64] <= cfg_data;
        mbps_pkg::REG_PATTERN_WORD1: pattern_r[1*64 +: 64] <= cfg_data;
        mbps_pkg::REG_PATTERN_WORD2: pattern_r[2*64 +: 64] <= cfg_data;
        mbps_pkg::REG_PATTERN_WORD3: pattern_r[3*64 +: 64] <= cfg_data;
        default: ;  // unknown index: write dropped
      endcase
    end
  end

  // lengths beyond the window are clamped to the window size
  logic [IW-1:0]   plen_ext;
  logic [IW-1:0]   len_clamp;
  logic [LenW-1:0] len;

  assign plen_ext  = IW'(plen_r);
  assign len_clamp = (plen_ext > IW'(MAX_PATTERN_LEN)) ? IW'(MAX_PATTERN_LEN) : plen_ext;
  assign len       = LenW'(len_clamp);

  // stage 1: window shift line
  mbps_pkg::s1_stat_t                   s1;
  logic [LenW-1:0]                      bytes_seen;
  logic [MAX_PATTERN_LEN*mbps_pkg::DataW-1:0] window;
  logic                                 s2_go;

  mbps_window #(
    .MAX_PATTERN_LEN (MAX_PATTERN_LEN),
    .LenW            (LenW)
  ) u_window (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .s2_go      (s2_go),
    .s1_stat    (s1),
    .bytes_seen (bytes_seen),
    .window     (window)
  );

  // stage 2: parallel compare
  logic match;

  mbps_match #(
    .MAX_PATTERN_LEN (MAX_PATTERN_LEN),
    .LenW            (LenW)
  ) u_match (
    .window     (window),
    .bytes_seen (bytes_seen),
    .len        (len),
    .care_mask  (care_r),
    .pattern    (pattern_r),
    .match      (match)
  );

  // result register
  logic                out_valid_r;
  mbps_pkg::out_item_t out_data_r;
  logic                done_r;     // matched, skipping to end of region
  logic                emit;
  logic                done_nxt;
  logic [AW-1:0]       start_sub;
  logic [AW-1:0]       addr;

  assign s2_go = s1.valid && (!out_valid_r || !out_stall);

  // zero length matches on the first byte, so its start is offset - 1
  assign start_sub = (len == '0) ? AW'(1) : AW'(len);
  assign addr      = base_r + s1.offset - start_sub;

  always_comb begin
    emit     = 1'b0;
    done_nxt = done_r;
    if (done_r) begin
      done_nxt = !s1.last;
    end else if (match) begin
      emit     = 1'b1;
      done_nxt = !s1.last;
    end else if (s1.last) begin
      emit = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      done_r      <= 1'b0;
    end else begin
      if (s2_go) begin
        done_r <= done_nxt;
      end
      if (s2_go && emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_go && emit) begin
      out_data_r.found         <= match;
      out_data_r.match_address <= match ? addr : '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // input backs up only behind a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("in_stall without a held result");

  // a not-found result carries a zero address
  a_notfound_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.found) |-> (out_data.match_address == '0))
    else $error("not-found result with non-zero address");

  // a match inside a region suppresses the rest of it
  a_done_set: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_go && !done_r && match && !s1.last) |=> done_r)
    else $error("match did not set done");

  // the region's last byte always rearms
  a_rearm: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_go && s1.last) |=> !done_r)
    else $error("last byte did not rearm");

endmodule
